// File: rtl/btmmc_pkg.sv
// Package for the Beaver triple multiply and MAC check block.
// Holds command and status codes and the controller/datapath command struct.
package btmmc_pkg;

  localparam int unsigned OPEN_DEPTH_DEFAULT = 64;

  typedef enum logic [2:0] {
    CMD_START      = 3'd0,
    CMD_START_SAVE = 3'd1,
    CMD_FINISH     = 3'd2,
    CMD_CHECK      = 3'd3,
    CMD_EMIT       = 3'd4,
    CMD_VERIFY     = 3'd5
  } cmd_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_CHEAT = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_SEQ   = 3'd4;

  // Multiplier operand selects, one per sequencing step.
  typedef enum logic [2:0] {
    MS_ED    = 3'd0,
    MS_B_EPS = 3'd1,
    MS_A_DEL = 3'd2,
    MS_MB_E  = 3'd3,
    MS_MA_D  = 3'd4,
    MS_KEY_ED = 3'd5,
    MS_CHK_V = 3'd6,
    MS_CHK_M = 3'd7
  } msel_t;

  typedef struct packed {
    logic  load;      // capture the input beat
    logic  start;     // perform start update
    logic  open;      // form epsilon and delta
    logic  mul;       // run one multiply step
    msel_t msel;
    logic  fin_done;  // commit finish result
    logic  rd;        // issue store read
    logic  chk_done;  // commit check step
    logic  emit;      // commit emit
    logic  verify;    // commit verify
    logic  bad;       // out of sequence or unknown
    logic  empty;     // nothing to check
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       pending_valid;
    logic       can_check;
  } sts_t;

endpackage

// File: rtl/btmmc_ctrl.sv
// Controller state machine for the Beaver triple multiply block.
// Depends on btmmc_pkg; drives the datapath through ctl_t.
module btmmc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_free,
  input  btmmc_pkg::sts_t   sts,
  output btmmc_pkg::ctl_t   ctl,
  output logic              busy
);
  import btmmc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_MUL  = 6'b000100,
    S_RD   = 6'b001000,
    S_CHK  = 6'b010000,
    S_WAIT = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [2:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 3'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    ctl = '0;
    ctl.msel = msel_t'(step);
    state_next = state;
    step_next = step;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          ctl.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (out_free) begin
          if (sts.cmd == CMD_START || sts.cmd == CMD_START_SAVE) begin
            ctl.start = 1'b1;
            state_next = S_IDLE;
          end else if (sts.cmd == CMD_FINISH) begin
            if (sts.pending_valid) begin
              ctl.open = 1'b1;
              step_next = 3'd0;
              state_next = S_MUL;
            end else begin
              ctl.bad = 1'b1;
              state_next = S_IDLE;
            end
          end else if (sts.cmd == CMD_CHECK) begin
            if (sts.can_check) begin
              ctl.rd = 1'b1;
              state_next = S_RD;
            end else begin
              ctl.empty = 1'b1;
              state_next = S_IDLE;
            end
          end else if (sts.cmd == CMD_EMIT) begin
            ctl.mul = 1'b1;
            ctl.msel = MS_KEY_ED;
            state_next = S_WAIT;
          end else if (sts.cmd == CMD_VERIFY) begin
            ctl.verify = 1'b1;
            state_next = S_IDLE;
          end else begin
            ctl.bad = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_MUL: begin
        ctl.mul = 1'b1;
        if (step == 3'd5) begin
          state_next = S_WAIT;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_RD: begin
        ctl.mul = 1'b1;
        ctl.msel = MS_CHK_V;
        state_next = S_CHK;
      end
      S_CHK: begin
        ctl.mul = 1'b1;
        ctl.msel = MS_CHK_M;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (sts.cmd == CMD_FINISH) ctl.fin_done = 1'b1;
        else if (sts.cmd == CMD_CHECK) ctl.chk_done = 1'b1;
        else ctl.emit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_fire |-> state == S_IDLE)
    else $error("beat accepted while busy");
  assert property (@(posedge clk) disable iff (rst) state == S_MUL |-> step <= 3'd5)
    else $error("multiply step overrun");
  assert property (@(posedge clk) disable iff (rst) state == S_RD |=> state == S_CHK)
    else $error("check sequence broken");
endmodule

// File: rtl/btmmc_dp.sv
// Datapath for the Beaver triple multiply block: shared multiplier,
// pending state, open store and check sums. Depends on btmmc_pkg.
module btmmc_dp #(
  parameter int unsigned OPEN_DEPTH = btmmc_pkg::OPEN_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  btmmc_pkg::ctl_t   ctl,
  input  logic              is_server,
  input  logic [31:0]       mac_key,
  input  logic [2:0]        in_cmd,
  input  logic [31:0]       in_left,
  input  logic [31:0]       in_right,
  input  logic [31:0]       in_mac_left,
  input  logic [31:0]       in_mac_right,
  input  logic [31:0]       in_ta,
  input  logic [31:0]       in_tb,
  input  logic [31:0]       in_tc,
  input  logic [31:0]       in_tma,
  input  logic [31:0]       in_tmb,
  input  logic [31:0]       in_tmc,
  output btmmc_pkg::sts_t   sts,
  output logic              out_set,
  output logic [31:0]       res_first,
  output logic [31:0]       res_second,
  output logic [2:0]        res_status
);
  import btmmc_pkg::*;

  localparam int unsigned AW = $clog2(OPEN_DEPTH);
  localparam int unsigned PW = $clog2(OPEN_DEPTH + 1);

  logic [2:0]  cmd;
  logic [31:0] lw, rw, mlw, mrw;
  logic [31:0] tin [6];
  logic [31:0] t [6];
  logic [31:0] peps, pdel, hmac0, hmac1, eps, del;
  logic        psave, pvalid;
  logic [PW-1:0] wp, cp;
  logic [31:0] vsum, msum, sigma;
  logic [31:0] ed, acc1, acc2, rd_v, rd_m, prod, ma, mb;
  logic [31:0] vmem [OPEN_DEPTH];
  logic [31:0] mmem [OPEN_DEPTH];
  logic        room;

  assign room = ({1'b0, wp} + 2) <= (PW+1)'(OPEN_DEPTH);
  assign sts.cmd = cmd;
  assign sts.pending_valid = pvalid;
  assign sts.can_check = cp < wp;

  always_comb begin
    case (ctl.msel)
      MS_ED:     begin ma = eps;    mb = del;  end
      MS_B_EPS:  begin ma = t[1];   mb = eps;  end
      MS_A_DEL:  begin ma = t[0];   mb = del;  end
      MS_MB_E:   begin ma = t[4];   mb = eps;  end
      MS_MA_D:   begin ma = t[3];   mb = del;  end
      MS_KEY_ED: begin ma = mac_key; mb = (cmd == CMD_EMIT) ? vsum : ed; end
      MS_CHK_V:  begin ma = rd_v;   mb = lw;   end
      default:   begin ma = rd_m;   mb = lw;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_v <= vmem[cp[AW-1:0]];
      rd_m <= mmem[cp[AW-1:0]];
    end
    if (ctl.fin_done && psave && room) begin
      vmem[wp[AW-1:0]] <= eps;
      mmem[wp[AW-1:0]] <= hmac0;
      vmem[AW'(wp + 1)] <= del;
      mmem[AW'(wp + 1)] <= hmac1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 32'(ma * mb);
    if (ctl.load) begin
      cmd <= in_cmd; lw <= in_left; rw <= in_right;
      mlw <= in_mac_left; mrw <= in_mac_right;
      tin[0] <= in_ta; tin[1] <= in_tb; tin[2] <= in_tc;
      tin[3] <= in_tma; tin[4] <= in_tmb; tin[5] <= in_tmc;
    end
    if (ctl.start) begin
      for (int i = 0; i < 6; i++) t[i] <= tin[i];
      hmac0 <= mlw - tin[3];
      hmac1 <= mrw - tin[4];
      peps <= lw - tin[0];
      pdel <= rw - tin[1];
    end
    if (ctl.open) begin
      eps <= peps + lw;
      del <= pdel + rw;
    end
    if (ctl.mul) begin
      case (ctl.msel)
        MS_B_EPS: begin ed <= prod; acc1 <= t[2]; end
        MS_A_DEL: acc1 <= acc1 + prod;
        MS_MB_E:  begin acc1 <= acc1 + prod + (is_server ? ed : 32'd0); acc2 <= t[5]; end
        MS_MA_D:  acc2 <= acc2 + prod;
        MS_KEY_ED: acc2 <= acc2 + prod;
        default: ;
      endcase
    end
    if (ctl.start || ctl.fin_done || ctl.chk_done || ctl.emit ||
        ctl.verify || ctl.bad || ctl.empty) begin
      res_first <= 32'd0; res_second <= 32'd0; res_status <= ST_OK;
      if (ctl.start) begin
        res_first <= lw - tin[0]; res_second <= rw - tin[1];
      end
      if (ctl.fin_done) begin
        res_first <= acc1;
        res_second <= acc2 + prod;
        if (psave && !room) res_status <= ST_FULL;
      end
      if (ctl.emit) res_first <= msum - prod;
      if (ctl.verify && (sigma + lw != 32'd0)) res_status <= ST_CHEAT;
      if (ctl.bad) res_status <= ST_SEQ;
      if (ctl.empty) res_status <= ST_EMPTY;
    end
    if (rst) begin
      pvalid <= 1'b0; psave <= 1'b0; wp <= '0; cp <= '0;
      vsum <= '0; msum <= '0; sigma <= '0;
      peps <= '0; pdel <= '0; hmac0 <= '0; hmac1 <= '0;
      for (int i = 0; i < 6; i++) t[i] <= '0;
    end else begin
      if (ctl.start) begin
        pvalid <= 1'b1;
        psave <= (cmd == CMD_START_SAVE);
      end
      if (ctl.fin_done) begin
        pvalid <= 1'b0; psave <= 1'b0;
        if (psave && room) wp <= PW'(wp + 2);
      end
      if (ctl.chk_done) begin
        msum <= msum + prod;
        cp <= PW'(cp + 1);
      end
      if (ctl.mul && ctl.msel == MS_CHK_M) vsum <= vsum + prod;
      if (ctl.emit) begin
        sigma <= msum - prod;
        vsum <= '0; msum <= '0;
        if (cp == wp) begin cp <= '0; wp <= '0; end
      end
    end
  end

  assign out_set = ctl.start || ctl.fin_done || ctl.chk_done || ctl.emit ||
                   ctl.verify || ctl.bad || ctl.empty;

  assert property (@(posedge clk) disable iff (rst) cp <= wp)
    else $error("check pointer passed write pointer");
  assert property (@(posedge clk) disable iff (rst) wp <= PW'(OPEN_DEPTH))
    else $error("write pointer overflow");
  assert property (@(posedge clk) disable iff (rst) ctl.fin_done |-> pvalid)
    else $error("finish without pending");
endmodule

// File: rtl/beaver_triple_multiply_mac_check.sv
// Top level of the Beaver triple multiply and MAC check block.
// Instantiates btmmc_ctrl and btmmc_dp; holds the APB registers and output register.
//
// Input beats arrive on s_axis_*; one result beat per input leaves on m_axis_*.
// s_axis_tdata: left_word, right_word, mac_left, mac_right, triple_a, triple_b,
// triple_c, triple_mac_a, triple_mac_b, triple_mac_c (lowest first); tuser: cmd.
// m_axis_tdata: first_out, second_out (lowest first); tuser: status.
// One beat is worked at a time; the finish step runs its six products through one
// shared 32x32 multiplier. The block takes a new beat once the previous result is
// in the output register; a stalled receiver holds the result, and the next beat
// waits in decode until the output register is free. Registers: is_server at 0x0,
// mac_key at 0x4, written through APB while idle, a rule on the user that the block
// does not enforce. Reset (rst, synchronous) clears all pointers, sums and pending
// state; the open store needs no clearing since only written entries are read.
module beaver_triple_multiply_mac_check #(
  parameter int unsigned OPEN_DEPTH = btmmc_pkg::OPEN_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [319:0] s_axis_tdata,  // left_word .. triple_mac_c
  input  logic [2:0]   s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // first_out, second_out
  output logic [2:0]   m_axis_tuser,  // status
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import btmmc_pkg::*;

  localparam logic [2:0] ADDR_SERVER = 3'd0;
  localparam logic [2:0] ADDR_KEY    = 3'd4;

  ctl_t ctl;
  sts_t sts;
  logic busy, in_fire, out_free, out_set, is_server;
  logic [31:0] mac_key, rf, rs;
  logic [2:0] rst_s;

  assign pready = 1'b1;
  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_server <= 1'b0;
      mac_key <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ADDR_SERVER: is_server <= pwdata[0];
        ADDR_KEY:    mac_key <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_SERVER: prdata = {31'd0, is_server};
      ADDR_KEY:    prdata = mac_key;
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_set) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  assign m_axis_tdata = {rs, rf};
  assign m_axis_tuser = rst_s;

  btmmc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .ctl(ctl), .busy(busy)
  );

  btmmc_dp #(.OPEN_DEPTH(OPEN_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .is_server(is_server), .mac_key(mac_key),
    .in_cmd(s_axis_tuser),
    .in_left(s_axis_tdata[31:0]), .in_right(s_axis_tdata[63:32]),
    .in_mac_left(s_axis_tdata[95:64]), .in_mac_right(s_axis_tdata[127:96]),
    .in_ta(s_axis_tdata[159:128]), .in_tb(s_axis_tdata[191:160]),
    .in_tc(s_axis_tdata[223:192]), .in_tma(s_axis_tdata[255:224]),
    .in_tmb(s_axis_tdata[287:256]), .in_tmc(s_axis_tdata[319:288]),
    .sts(sts), .out_set(out_set),
    .res_first(rf), .res_second(rs), .res_status(rst_s)
  );
endmodule
